// ----- design/gww_pkg.sv -----
`default_nettype none
package gww_pkg;

	localparam int WORD_MAX_DEF = 62;

	localparam logic [7:0] CH_SPACE    = 8'd32;
	localparam logic [7:0] CH_TAB      = 8'd9;
	localparam logic [7:0] CH_NL       = 8'd10;
	localparam logic [7:0] WIDTH_RESET = 8'd75;

	localparam logic OP_BYTE = 1'b0;
	localparam logic OP_EOS  = 1'b1;

	localparam int         CFG_AW         = 3;
	localparam logic       REG_LINE_WIDTH = 1'b0;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_DECIDE,
		ST_BRK,
		ST_SEP,
		ST_FETCH,
		ST_WORD,
		ST_CLOSE
	} state_t;

	// emission plan for one input: line break, separator space, word bytes, closing newline
	typedef struct packed {
		logic brk;
		logic sep;
		logic word;
		logic close;
	} plan_t;

endpackage
`default_nettype wire

// ----- design/gww_in_if.sv -----
`default_nettype none
interface gww_in_if;
	logic       valid;
	logic       ready;
	logic       opcode;
	logic [7:0] char_code;

	modport source (output valid, opcode, char_code, input ready);
	modport sink (input valid, opcode, char_code, output ready);
endinterface
`default_nettype wire

// ----- design/gww_out_if.sv -----
`default_nettype none
interface gww_out_if;
	logic       valid;
	logic       ready;
	logic [7:0] out_char;
	logic       last;

	modport source (output valid, out_char, last, input ready);
	modport sink (input valid, out_char, last, output ready);
endinterface
`default_nettype wire

// ----- design/gww_cfg.sv -----
`default_nettype none
module gww_cfg (
	input  wire logic                      clk,
	input  wire logic                      arst_n,
	input  wire logic                      psel,
	input  wire logic                      penable,
	input  wire logic                      pwrite,
	input  wire logic [gww_pkg::CFG_AW-1:0] paddr,
	input  wire logic [31:0]               pwdata,
	output logic      [31:0]               prdata,
	output logic                           pready,
	output logic      [7:0]                line_width
);

	logic [7:0] line_width_q;
	logic       wr_hit;

	assign pready = 1'b1;
	assign wr_hit = psel && penable && pwrite && (paddr[2] == gww_pkg::REG_LINE_WIDTH);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			line_width_q <= gww_pkg::WIDTH_RESET;
		end else if (wr_hit) begin
			line_width_q <= pwdata[7:0];
		end
	end

	always_comb begin
		if (paddr[2] == gww_pkg::REG_LINE_WIDTH) begin
			prdata = {24'd0, line_width_q};
		end else begin
			prdata = 32'd0;
		end
	end

	assign line_width = line_width_q;

endmodule
`default_nettype wire

// ----- design/gww_word_buf.sv -----
`default_nettype none
module gww_word_buf #(
	parameter int DEPTH = gww_pkg::WORD_MAX_DEF,
	parameter int AW    = 6
) (
	input  wire logic          clk,
	input  wire logic          wr_en,
	input  wire logic [AW-1:0] wr_addr,
	input  wire logic [7:0]    wr_data,
	input  wire logic          rd_en,
	input  wire logic [AW-1:0] rd_addr,
	output logic      [7:0]    rd_data
);

	logic [7:0] mem [DEPTH];
	logic [7:0] rd_data_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data_q <= mem[rd_addr];
		end
	end

	assign rd_data = rd_data_q;

endmodule
`default_nettype wire

// ----- design/greedy_word_wrap_stream.sv -----
// A word byte is registered on transfer and written to the buffer in the decide state; no output.
// A blank, paragraph break or end of stream: a decide state, then a break or space, each
// word byte fetched from the registered buffer read port and then emitted, and a closing
// newline, each output waiting while dout stalls; ready again the cycle after the last output.
// Input is taken only when idle: a new item waits until the last is done; dout stalls add.
// Reset (arst_n, async): idle, column 0, empty word, line_width 75; buffer not cleared.
`default_nettype none
module greedy_word_wrap_stream #(
	parameter int WORD_MAX = gww_pkg::WORD_MAX_DEF
) (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	gww_in_if.sink                          din,
	gww_out_if.source                       dout,
	input  wire logic                       psel,
	input  wire logic                       penable,
	input  wire logic                       pwrite,
	input  wire logic [gww_pkg::CFG_AW-1:0] paddr,
	input  wire logic [31:0]                pwdata,
	output logic      [31:0]                prdata,
	output logic                            pready
);

	localparam int LW = $clog2(WORD_MAX + 1);
	localparam int AW = (WORD_MAX > 1) ? $clog2(WORD_MAX) : 1;

	gww_pkg::state_t state_q, state_d;
	gww_pkg::plan_t  plan_q, plan_d;

	logic          op_q;
	logic [7:0]    ch_q;
	logic [LW-1:0] wlen_q, wlen_d;
	logic [LW-1:0] idx_q, idx_d;
	logic [7:0]    col_q, col_d;
	logic          np_q, np_d;
	logic          out_valid_q;
	logic [7:0]    out_char_q;
	logic          out_last_q;

	logic [7:0]    line_width;
	logic          wr_en, rd_en;
	logic [7:0]    rd_data;
	logic          ld, ld_last;
	logic [7:0]    ld_char;
	logic          can_emit;
	logic          in_fire;

	logic [9:0]    sum;
	logic          over, wl_nz, col_nz, brk_w, sep_w, blank, byte_last;
	logic [7:0]    col_flush;

	gww_cfg u_cfg (
		.clk        (clk),
		.arst_n     (arst_n),
		.psel       (psel),
		.penable    (penable),
		.pwrite     (pwrite),
		.paddr      (paddr),
		.pwdata     (pwdata),
		.prdata     (prdata),
		.pready     (pready),
		.line_width (line_width)
	);

	gww_word_buf #(
		.DEPTH (WORD_MAX),
		.AW    (AW)
	) u_buf (
		.clk     (clk),
		.wr_en   (wr_en),
		.wr_addr (wlen_q[AW-1:0]),
		.wr_data (ch_q),
		.rd_en   (rd_en),
		.rd_addr (idx_q[AW-1:0]),
		.rd_data (rd_data)
	);

	function automatic gww_pkg::state_t first_of(gww_pkg::plan_t p);
		gww_pkg::state_t s;
		if (p.brk) begin
			s = gww_pkg::ST_BRK;
		end else if (p.sep) begin
			s = gww_pkg::ST_SEP;
		end else if (p.word) begin
			s = gww_pkg::ST_FETCH;
		end else if (p.close) begin
			s = gww_pkg::ST_CLOSE;
		end else begin
			s = gww_pkg::ST_IDLE;
		end
		return s;
	endfunction

	// shared adder: column + 1 + word length, used for the wrap test and the new column
	assign sum    = {2'b00, col_q} + 10'(wlen_q) + 10'd1;
	assign over   = sum > {2'b00, line_width};
	assign wl_nz  = wlen_q != '0;
	assign col_nz = col_q != 8'd0;
	assign brk_w  = wl_nz && col_nz && over;
	assign sep_w  = wl_nz && col_nz && !over;
	assign blank  = (ch_q == gww_pkg::CH_SPACE) || (ch_q == gww_pkg::CH_TAB)
		|| (ch_q == gww_pkg::CH_NL);

	always_comb begin
		if (!wl_nz) begin
			col_flush = col_q;
		end else if (!col_nz || brk_w) begin
			col_flush = 8'(wlen_q);
		end else if (sum > 10'd255) begin
			col_flush = 8'hFF;
		end else begin
			col_flush = sum[7:0];
		end
	end

	assign can_emit  = !out_valid_q || dout.ready;
	assign din.ready = state_q == gww_pkg::ST_IDLE;
	assign in_fire   = din.valid && din.ready;
	assign byte_last = LW'(idx_q + 1'b1) == wlen_q;

	always_comb begin
		state_d = state_q;
		plan_d  = plan_q;
		col_d   = col_q;
		np_d    = np_q;
		wlen_d  = wlen_q;
		idx_d   = idx_q;
		wr_en   = 1'b0;
		rd_en   = 1'b0;
		ld      = 1'b0;
		ld_char = gww_pkg::CH_NL;
		ld_last = 1'b0;
		unique case (state_q)
			gww_pkg::ST_IDLE: begin
				if (din.valid) begin
					state_d = gww_pkg::ST_DECIDE;
				end
			end
			gww_pkg::ST_DECIDE: begin
				idx_d = '0;
				priority if (op_q == gww_pkg::OP_EOS) begin
					plan_d  = '{brk: brk_w, sep: sep_w, word: wl_nz, close: wl_nz || col_nz};
					col_d   = 8'd0;
					np_d    = 1'b0;
					state_d = first_of(plan_d);
				end else if (np_q && ch_q == gww_pkg::CH_NL) begin
					plan_d  = '{brk: col_nz, sep: 1'b0, word: 1'b0, close: 1'b1};
					col_d   = 8'd0;
					np_d    = 1'b0;
					state_d = first_of(plan_d);
				end else if (blank) begin
					plan_d  = '{brk: brk_w, sep: sep_w, word: wl_nz, close: 1'b0};
					col_d   = col_flush;
					np_d    = ch_q == gww_pkg::CH_NL;
					state_d = first_of(plan_d);
				end else begin
					np_d    = 1'b0;
					state_d = gww_pkg::ST_IDLE;
					if (wlen_q < LW'(WORD_MAX)) begin
						wr_en  = 1'b1;
						wlen_d = LW'(wlen_q + 1'b1);
					end
				end
			end
			gww_pkg::ST_BRK: begin
				if (can_emit) begin
					ld      = 1'b1;
					ld_char = gww_pkg::CH_NL;
					ld_last = !plan_q.sep && !plan_q.word && !plan_q.close;
					state_d = first_of('{brk: 1'b0, sep: plan_q.sep, word: plan_q.word,
						close: plan_q.close});
				end
			end
			gww_pkg::ST_SEP: begin
				if (can_emit) begin
					ld      = 1'b1;
					ld_char = gww_pkg::CH_SPACE;
					ld_last = !plan_q.word && !plan_q.close;
					state_d = first_of('{brk: 1'b0, sep: 1'b0, word: plan_q.word,
						close: plan_q.close});
				end
			end
			gww_pkg::ST_FETCH: begin
				rd_en   = 1'b1;
				state_d = gww_pkg::ST_WORD;
			end
			gww_pkg::ST_WORD: begin
				if (can_emit) begin
					ld      = 1'b1;
					ld_char = rd_data;
					ld_last = byte_last && !plan_q.close;
					if (byte_last) begin
						wlen_d  = '0;
						state_d = plan_q.close ? gww_pkg::ST_CLOSE : gww_pkg::ST_IDLE;
					end else begin
						idx_d   = LW'(idx_q + 1'b1);
						state_d = gww_pkg::ST_FETCH;
					end
				end
			end
			gww_pkg::ST_CLOSE: begin
				if (can_emit) begin
					ld      = 1'b1;
					ld_char = gww_pkg::CH_NL;
					ld_last = 1'b1;
					state_d = gww_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = gww_pkg::ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= gww_pkg::ST_IDLE;
			plan_q      <= '0;
			wlen_q      <= '0;
			idx_q       <= '0;
			col_q       <= 8'd0;
			np_q        <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			plan_q  <= plan_d;
			wlen_q  <= wlen_d;
			idx_q   <= idx_d;
			col_q   <= col_d;
			np_q    <= np_d;
			if (ld) begin
				out_valid_q <= 1'b1;
			end else if (dout.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_fire) begin
			op_q <= din.opcode;
			ch_q <= din.char_code;
		end
		if (ld) begin
			out_char_q <= ld_char;
			out_last_q <= ld_last;
		end
	end

	assign dout.valid    = out_valid_q;
	assign dout.out_char = out_char_q;
	assign dout.last     = out_last_q;

	a_wlen_bound: assert property (@(posedge clk) disable iff (!arst_n)
		wlen_q <= LW'(WORD_MAX))
		else $error("word length beyond buffer capacity");

	a_fire_decide: assert property (@(posedge clk) disable iff (!arst_n)
		in_fire |=> state_q == gww_pkg::ST_DECIDE)
		else $error("transfer not followed by decide");

	a_word_after_fetch: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == gww_pkg::ST_WORD && $past(state_q) != gww_pkg::ST_WORD)
		|-> $past(state_q) == gww_pkg::ST_FETCH)
		else $error("word byte emitted without buffer read");

	a_last_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(ld && ld_last) |=> state_q == gww_pkg::ST_IDLE)
		else $error("last byte did not end the sequence");

	a_eos_col: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == gww_pkg::ST_DECIDE && op_q == gww_pkg::OP_EOS)
		|=> (col_q == 8'd0 && !np_q))
		else $error("end of stream left column or newline state");

endmodule
`default_nettype wire
